// ===== src/zoh_pkg.sv =====
// ----------------------------------------------------------------------------
// Trace energy integrator package
// Shared state encoding, operation and status codes, and fixed constants.
// ----------------------------------------------------------------------------
package zoh_pkg;

  // Operation codes carried in the input transaction's tuser.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK             = 3'd0,
    STS_NOT_INCREASING = 3'd1,
    STS_FULL           = 3'd2,
    STS_BAD_INTERVAL   = 3'd3,
    STS_TOO_LONG       = 3'd4,
    STS_NO_SENTINEL    = 3'd5,
    STS_OVERFLOW       = 3'd6,
    STS_BAD_CONFIG     = 3'd7
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_AREA = 2'd1;
  localparam logic [1:0] REG_EFF  = 2'd2;

  // Efficiency of exactly 1.0 in Q1.16.
  localparam logic [16:0] EFF_ONE = 17'd65536;

  // Longest allowed gap or interval: 2^53 ms.
  localparam logic [63:0] LONGEST_SPAN = 64'h0020_0000_0000_0000;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WAIT,
    ST_A_EVAL,
    ST_A_POST,
    ST_CV0,
    ST_CV1,
    ST_CV2,
    ST_CV3,
    ST_A_WR,
    ST_I_RD0,
    ST_I_EV0,
    ST_I_RDL,
    ST_I_EVL,
    ST_I_BS,
    ST_I_BSE,
    ST_I_RDI,
    ST_I_EVI,
    ST_I_DONE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_FIN
  } state_t;

endpackage

// ===== src/zoh_trace_energy_integrator.sv =====
// ----------------------------------------------------------------------------
// Zero-order-hold trace energy integrator
// Sample table with running prefix energy, answering interval energy queries.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream (in_tvalid/in_tready/in_tdata/in_tuser) carries one
//   command per transaction: append a sample, query an interval, clear the
//   table or do nothing. Every command returns exactly one result
//   transaction on the output stream (energy in out_tdata, status in
//   out_tuser). Configuration writes use cfg_valid/cfg_ready with a register
//   index and data, and are taken in any cycle; they should be issued only
//   while no command is in flight.
//   One command is worked on at a time; in_tready is high only when the
//   sequencer is idle. All products go through one shared 32x32 multiplier.
//   A rejected command, clear or no-op goes from dispatch straight to the
//   result. An append to a non-empty table reads the last sample and forms
//   the gap product; in irradiance mode an append converts its value. A
//   query makes a pass for the start and one for the end time, each with up
//   to one product and a binary search of about log2(sample count) + 1
//   steps; each step costs an address cycle, a memory read and a compare.
//   in_tready rises in the same cycle that the result is loaded.
//   After reset the table is empty and all configuration registers are zero.
//   A finished result waits in the output register while the receiver
//   stalls; the sequencer then holds until that register is free.
// ----------------------------------------------------------------------------
module zoh_trace_energy_integrator #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input command stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: sample_time[63:0], sample_value[95:64], start_time[159:96],
  //        end_time[223:160]
  input  logic [223:0] in_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]   in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: energy[63:0]
  output logic [63:0]  out_tdata,
  // tuser: status[2:0]
  output logic [2:0]   out_tuser,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // Sequencer state.
  zoh_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  // Configuration registers.
  logic        irr_r;
  logic [31:0] area_r;
  logic [16:0] eff_r;

  // Table state.
  logic [CW-1:0] count_r, count_nxt;
  logic          lvz_r, lvz_nxt;

  // Latched command.
  zoh_pkg::op_t op_r;
  logic [63:0]  stime_r, start_r, end_r;
  logic [31:0]  sval_r;

  // Working registers.
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [63:0]   cur_t_r, cur_t_nxt;
  logic          pass_r, pass_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   pw_r, pw_nxt;
  logic [53:0]   span_r, span_nxt;
  logic [63:0]   base_r, base_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   res_r, res_nxt;
  logic [63:0]   a_r, a_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [63:0]   pfx_new_r, pfx_new_nxt;
  logic [31:0]   pconv_r, pconv_nxt;
  logic [63:0]   energy_r, energy_nxt;
  zoh_pkg::status_t status_r, status_nxt;

  // Output register.
  logic        out_valid_r;
  logic [63:0] out_energy_r;
  logic [2:0]  out_status_r;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_r;

  // Sample memories and their registered read data.
  logic [63:0] time_mem   [MAX_SAMPLES];
  logic [31:0] power_mem  [MAX_SAMPLES];
  logic [63:0] prefix_mem [MAX_SAMPLES];
  logic [63:0] time_q, prefix_q;
  logic [31:0] power_q;

  // Decision terms.
  logic          cfg_bad, tbl_full, tbl_empty, no_sent, bad_iv, long_iv;
  logic          a_notinc, a_long, bs_go, fin_go;
  logic [63:0]   a_gap, iv_len;
  logic [CW-1:0] cnt_m1, mid, lo_m1;
  logic [32:0]   sum33;
  logic [64:0]   sum65;
  logic [63:0]   scaled;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == zoh_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_energy_r;
  assign out_tuser  = out_status_r;

  assign cfg_bad   = irr_r ? ((area_r == 32'd0) || (eff_r == 17'd0) ||
                              (eff_r > zoh_pkg::EFF_ONE))
                           : ((area_r != 32'd0) || (eff_r != 17'd0));
  assign tbl_full  = (count_r >= CW'(MAX_SAMPLES));
  assign tbl_empty = (count_r == '0);
  assign no_sent   = tbl_empty || !lvz_r;
  assign bad_iv    = (start_r >= end_r);
  assign iv_len    = end_r - start_r;
  assign long_iv   = (iv_len > zoh_pkg::LONGEST_SPAN);
  assign a_notinc  = (stime_r <= time_q);
  assign a_gap     = stime_r - time_q;
  assign a_long    = (a_gap > zoh_pkg::LONGEST_SPAN);
  assign cnt_m1    = count_r - CW'(1);
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1     = lo_r - CW'(1);
  assign bs_go     = (lo_r < hi_r);
  assign fin_go    = !out_valid_r || out_tready;
  assign sum33     = {1'b0, acc_r[63:32]} + {1'b0, mul_p_r[31:0]};
  assign sum65     = {1'b0, base_r} + {1'b0, acc_r};
  assign scaled    = acc_r + {32'd0, mul_p_r[63:32]};

  // Multiplier operand selection by state.
  always_comb begin
    mul_a = pw_r;
    mul_b = span_r[31:0];
    unique case (state_r)
      zoh_pkg::ST_M1: begin
        mul_b = {10'd0, span_r[53:32]};
      end
      zoh_pkg::ST_CV0: begin
        mul_a = sval_r;
        mul_b = area_r;
      end
      zoh_pkg::ST_CV1: begin
        mul_a = mul_p_r[63:32];
        mul_b = {15'd0, eff_r};
      end
      zoh_pkg::ST_CV2: begin
        mul_a = prod_r[31:0];
        mul_b = {15'd0, eff_r};
      end
      default: begin
        mul_a = pw_r;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      zoh_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = zoh_pkg::ST_DISPATCH;
      end
      zoh_pkg::ST_DISPATCH: begin
        unique case (op_r)
          zoh_pkg::OP_APPEND: begin
            if (cfg_bad || tbl_full) begin
              state_nxt = zoh_pkg::ST_FIN;
            end else if (tbl_empty) begin
              state_nxt = irr_r ? zoh_pkg::ST_CV0 : zoh_pkg::ST_A_WR;
            end else begin
              state_nxt = zoh_pkg::ST_WAIT;
              ret_nxt   = zoh_pkg::ST_A_EVAL;
            end
          end
          zoh_pkg::OP_QUERY: begin
            if (no_sent || bad_iv || long_iv) state_nxt = zoh_pkg::ST_FIN;
            else state_nxt = zoh_pkg::ST_I_RD0;
          end
          default: begin
            state_nxt = zoh_pkg::ST_FIN;
          end
        endcase
      end
      zoh_pkg::ST_WAIT: begin
        state_nxt = ret_r;
      end
      zoh_pkg::ST_A_EVAL: begin
        if (a_notinc || a_long) begin
          state_nxt = zoh_pkg::ST_FIN;
        end else begin
          state_nxt = zoh_pkg::ST_M0;
          ret_nxt   = zoh_pkg::ST_A_POST;
        end
      end
      zoh_pkg::ST_A_POST: begin
        if (ovf_r) state_nxt = zoh_pkg::ST_FIN;
        else state_nxt = irr_r ? zoh_pkg::ST_CV0 : zoh_pkg::ST_A_WR;
      end
      zoh_pkg::ST_CV0: state_nxt = zoh_pkg::ST_CV1;
      zoh_pkg::ST_CV1: state_nxt = zoh_pkg::ST_CV2;
      zoh_pkg::ST_CV2: state_nxt = zoh_pkg::ST_CV3;
      zoh_pkg::ST_CV3: state_nxt = zoh_pkg::ST_A_WR;
      zoh_pkg::ST_A_WR: state_nxt = zoh_pkg::ST_FIN;
      zoh_pkg::ST_I_RD0: begin
        state_nxt = zoh_pkg::ST_WAIT;
        ret_nxt   = zoh_pkg::ST_I_EV0;
      end
      zoh_pkg::ST_I_EV0: begin
        state_nxt = (cur_t_r <= time_q) ? zoh_pkg::ST_I_DONE : zoh_pkg::ST_I_RDL;
      end
      zoh_pkg::ST_I_RDL: begin
        state_nxt = zoh_pkg::ST_WAIT;
        ret_nxt   = zoh_pkg::ST_I_EVL;
      end
      zoh_pkg::ST_I_EVL: begin
        state_nxt = (cur_t_r >= time_q) ? zoh_pkg::ST_I_DONE : zoh_pkg::ST_I_BS;
      end
      zoh_pkg::ST_I_BS: begin
        if (bs_go) begin
          state_nxt = zoh_pkg::ST_WAIT;
          ret_nxt   = zoh_pkg::ST_I_BSE;
        end else begin
          state_nxt = zoh_pkg::ST_I_RDI;
        end
      end
      zoh_pkg::ST_I_BSE: state_nxt = zoh_pkg::ST_I_BS;
      zoh_pkg::ST_I_RDI: begin
        state_nxt = zoh_pkg::ST_WAIT;
        ret_nxt   = zoh_pkg::ST_I_EVI;
      end
      zoh_pkg::ST_I_EVI: begin
        state_nxt = zoh_pkg::ST_M0;
        ret_nxt   = zoh_pkg::ST_I_DONE;
      end
      zoh_pkg::ST_I_DONE: begin
        state_nxt = pass_r ? zoh_pkg::ST_FIN : zoh_pkg::ST_I_RD0;
      end
      zoh_pkg::ST_M0: state_nxt = zoh_pkg::ST_M1;
      zoh_pkg::ST_M1: state_nxt = zoh_pkg::ST_M2;
      zoh_pkg::ST_M2: state_nxt = zoh_pkg::ST_M3;
      zoh_pkg::ST_M3: state_nxt = ret_r;
      zoh_pkg::ST_FIN: begin
        if (fin_go) state_nxt = zoh_pkg::ST_IDLE;
      end
      default: state_nxt = zoh_pkg::ST_IDLE;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    count_nxt   = count_r;
    lvz_nxt     = lvz_r;
    addr_nxt    = addr_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    cur_t_nxt   = cur_t_r;
    pass_nxt    = pass_r;
    ovf_nxt     = ovf_r;
    pw_nxt      = pw_r;
    span_nxt    = span_r;
    base_nxt    = base_r;
    acc_nxt     = acc_r;
    res_nxt     = res_r;
    a_nxt       = a_r;
    prod_nxt    = prod_r;
    pfx_new_nxt = pfx_new_r;
    pconv_nxt   = pconv_r;
    energy_nxt  = energy_r;
    status_nxt  = status_r;
    unique case (state_r)
      zoh_pkg::ST_DISPATCH: begin
        energy_nxt = 64'd0;
        status_nxt = zoh_pkg::STS_OK;
        ovf_nxt    = 1'b0;
        unique case (op_r)
          zoh_pkg::OP_APPEND: begin
            if (cfg_bad) begin
              status_nxt = zoh_pkg::STS_BAD_CONFIG;
            end else if (tbl_full) begin
              status_nxt = zoh_pkg::STS_FULL;
            end else if (tbl_empty) begin
              pfx_new_nxt = 64'd0;
              pconv_nxt   = sval_r;
            end else begin
              addr_nxt = cnt_m1[AW-1:0];
            end
          end
          zoh_pkg::OP_QUERY: begin
            if (no_sent) status_nxt = zoh_pkg::STS_NO_SENTINEL;
            else if (bad_iv) status_nxt = zoh_pkg::STS_BAD_INTERVAL;
            else if (long_iv) status_nxt = zoh_pkg::STS_TOO_LONG;
            cur_t_nxt = start_r;
            pass_nxt  = 1'b0;
          end
          zoh_pkg::OP_CLEAR: begin
            count_nxt = '0;
            lvz_nxt   = 1'b0;
          end
          default: begin
            status_nxt = zoh_pkg::STS_OK;
          end
        endcase
      end
      zoh_pkg::ST_A_EVAL: begin
        if (a_notinc) begin
          status_nxt = zoh_pkg::STS_NOT_INCREASING;
        end else if (a_long) begin
          status_nxt = zoh_pkg::STS_TOO_LONG;
        end else begin
          pw_nxt   = power_q;
          span_nxt = a_gap[53:0];
          base_nxt = prefix_q;
        end
      end
      zoh_pkg::ST_A_POST: begin
        if (ovf_r) status_nxt = zoh_pkg::STS_OVERFLOW;
        pfx_new_nxt = res_r;
        pconv_nxt   = sval_r;
      end
      zoh_pkg::ST_CV1: prod_nxt = mul_p_r;
      zoh_pkg::ST_CV2: acc_nxt = mul_p_r;
      zoh_pkg::ST_CV3: begin
        pconv_nxt = (scaled[63:32] != 32'd0) ? 32'hFFFF_FFFF : scaled[31:0];
      end
      zoh_pkg::ST_A_WR: begin
        count_nxt = count_r + CW'(1);
        lvz_nxt   = (sval_r == 32'd0);
      end
      zoh_pkg::ST_I_RD0: addr_nxt = '0;
      zoh_pkg::ST_I_EV0: res_nxt = 64'd0;
      zoh_pkg::ST_I_RDL: addr_nxt = cnt_m1[AW-1:0];
      zoh_pkg::ST_I_EVL: begin
        res_nxt = prefix_q;
        lo_nxt  = '0;
        hi_nxt  = count_r;
      end
      zoh_pkg::ST_I_BS: begin
        if (bs_go) addr_nxt = mid[AW-1:0];
      end
      zoh_pkg::ST_I_BSE: begin
        if (time_q <= cur_t_r) lo_nxt = CW'(addr_r) + CW'(1);
        else hi_nxt = CW'(addr_r);
      end
      zoh_pkg::ST_I_RDI: addr_nxt = lo_m1[AW-1:0];
      zoh_pkg::ST_I_EVI: begin
        pw_nxt   = power_q;
        span_nxt = 54'(cur_t_r - time_q);
        base_nxt = prefix_q;
      end
      zoh_pkg::ST_I_DONE: begin
        if (!pass_r) begin
          a_nxt     = res_r;
          cur_t_nxt = end_r;
          pass_nxt  = 1'b1;
        end else if (ovf_r || (res_r < a_r)) begin
          status_nxt = zoh_pkg::STS_OVERFLOW;
        end else begin
          energy_nxt = res_r - a_r;
        end
      end
      zoh_pkg::ST_M1: acc_nxt = mul_p_r;
      zoh_pkg::ST_M2: begin
        ovf_nxt = ovf_r || (mul_p_r[63:32] != 32'd0) || sum33[32];
        acc_nxt = {sum33[31:0], acc_r[31:0]};
      end
      zoh_pkg::ST_M3: begin
        ovf_nxt = ovf_r || sum65[64];
        res_nxt = sum65[63:0];
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zoh_pkg::ST_IDLE;
      ret_r       <= zoh_pkg::ST_IDLE;
      count_r     <= '0;
      lvz_r       <= 1'b0;
      irr_r       <= 1'b0;
      area_r      <= 32'd0;
      eff_r       <= 17'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      count_r <= count_nxt;
      lvz_r   <= lvz_nxt;
      // Configuration write transaction.
      if (cfg_valid) begin
        unique case (cfg_index)
          zoh_pkg::REG_MODE: irr_r  <= cfg_data[0];
          zoh_pkg::REG_AREA: area_r <= cfg_data;
          zoh_pkg::REG_EFF:  eff_r  <= cfg_data[16:0];
          default:           irr_r  <= irr_r;
        endcase
      end
      // Result register handshake.
      if ((state_r == zoh_pkg::ST_FIN) && fin_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= zoh_pkg::op_t'(in_tuser);
      stime_r <= in_tdata[63:0];
      sval_r  <= in_tdata[95:64];
      start_r <= in_tdata[159:96];
      end_r   <= in_tdata[223:160];
    end
    if ((state_r == zoh_pkg::ST_FIN) && fin_go) begin
      out_energy_r <= energy_r;
      out_status_r <= status_r;
    end
    addr_r    <= addr_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    cur_t_r   <= cur_t_nxt;
    pass_r    <= pass_nxt;
    ovf_r     <= ovf_nxt;
    pw_r      <= pw_nxt;
    span_r    <= span_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    res_r     <= res_nxt;
    a_r       <= a_nxt;
    prod_r    <= prod_nxt;
    pfx_new_r <= pfx_new_nxt;
    pconv_r   <= pconv_nxt;
    energy_r  <= energy_nxt;
    status_r  <= status_nxt;
    mul_p_r   <= mul_a * mul_b;
  end

  // Sample memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == zoh_pkg::ST_A_WR) begin
      time_mem[count_r[AW-1:0]]   <= stime_r;
      power_mem[count_r[AW-1:0]]  <= pconv_r;
      prefix_mem[count_r[AW-1:0]] <= pfx_new_r;
    end
    time_q   <= time_mem[addr_r];
    power_q  <= power_mem[addr_r];
    prefix_q <= prefix_mem[addr_r];
  end

endmodule
